### rtl/izn_pkg.sv
// ---------------------------------------------------------------------------
// izn_pkg: shared types, constants and helpers for the neuron step core
// Holds the default parameter values, the register index codes, the
// controller-to-datapath command and status types, and 32-bit saturation.
// ---------------------------------------------------------------------------
`default_nettype none

package izn_pkg;

   localparam int DATA_W      = 32;
   localparam int DELAY_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = 64;
   localparam int WIDE_W      = 66;
   localparam int DRIVE_W     = 34;

   localparam int DELAY_DEPTH_DEF = 64;
   localparam int GAIN_SHIFT_DEF  = 4;
   localparam int FRAC_BITS_DEF   = 16;
   localparam logic signed [DATA_W-1:0] BIAS_CURRENT_DEF = 32'sd0;
   localparam logic signed [DATA_W-1:0] INITIAL_V_DEF    = -32'sd4259840;
   localparam logic signed [DATA_W-1:0] INITIAL_U_DEF    = 32'sd0;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_ADD  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_K_STEP      = 3'd0,
      CSR_V_REST      = 3'd1,
      CSR_V_THRESHOLD = 3'd2,
      CSR_V_PEAK      = 3'd3,
      CSR_V_RESET     = 3'd4,
      CSR_U_JUMP      = 3'd5,
      CSR_A_STEP      = 3'd6,
      CSR_AB_STEP     = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LATCH,
      DP_READ,
      DP_ACCUM,
      DP_MUL_AU,
      DP_MUL_AB,
      DP_MUL_K,
      DP_SUM,
      DP_VSUM,
      DP_COMMIT
   } dp_op_type;

   typedef struct packed {
      logic kind_add;
      logic clear_last;
   } dp_status_type;

   // Clamp a wide signed value to the 32-bit signed range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x[WIDE_W-1:DATA_W-1] == '0 || x[WIDE_W-1:DATA_W-1] == '1) begin
         r = x[DATA_W-1:0];
      end else if (x[WIDE_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/izn_ram.sv
// ---------------------------------------------------------------------------
// izn_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module izn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/izn_ctrl.sv
// ---------------------------------------------------------------------------
// izn_ctrl: sequencer for the neuron step core
// Steps one item at a time through the datapath and owns the result valid.
// ---------------------------------------------------------------------------
`default_nettype none

module izn_ctrl
   import izn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_op_type     cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_ACCUM,
      S_MUL_AU,
      S_MUL_AB,
      S_MUL_K,
      S_SUM,
      S_VSUM,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise the result once the output word is free, else drop it when taken
         if ((state_ff == S_COMMIT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= status.kind_add ? S_ACCUM : S_MUL_AU;
            end
            S_ACCUM:  state_ff <= S_COMMIT;
            S_MUL_AU: state_ff <= S_MUL_AB;
            S_MUL_AB: state_ff <= S_MUL_K;
            S_MUL_K:  state_ff <= S_SUM;
            S_SUM:    state_ff <= S_VSUM;
            S_VSUM:   state_ff <= S_COMMIT;
            S_COMMIT: begin
               // hold until the output word is free
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      unique case (state_ff)
         S_CLEAR:  cmd = DP_CLEAR;
         S_IDLE:   cmd = req_valid ? DP_LATCH : DP_NOP;
         S_READ:   cmd = DP_READ;
         S_ACCUM:  cmd = DP_ACCUM;
         S_MUL_AU: cmd = DP_MUL_AU;
         S_MUL_AB: cmd = DP_MUL_AB;
         S_MUL_K:  cmd = DP_MUL_K;
         S_SUM:    cmd = DP_SUM;
         S_VSUM:   cmd = DP_VSUM;
         S_COMMIT: cmd = (slot_free && !status.kind_add) ? DP_COMMIT : DP_NOP;
         default:  cmd = DP_NOP;
      endcase
   end

endmodule

`default_nettype wire

### rtl/izn_datapath.sv
// ---------------------------------------------------------------------------
// izn_datapath: arithmetic and state of the neuron step core
// Config registers, neuron state, delay ring, one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module izn_datapath
   import izn_pkg::*;
#(
   parameter int                        DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int                        GAIN_SHIFT   = GAIN_SHIFT_DEF,
   parameter logic signed [DATA_W-1:0]  BIAS_CURRENT = BIAS_CURRENT_DEF,
   parameter logic signed [DATA_W-1:0]  INITIAL_V    = INITIAL_V_DEF,
   parameter logic signed [DATA_W-1:0]  INITIAL_U    = INITIAL_U_DEF,
   parameter int                        FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_op_type                  cmd,
   output dp_status_type              status,
   input  logic                       req_kind,
   input  logic signed [DATA_W-1:0]   req_current,
   input  logic [DELAY_W-1:0]         req_delay,
   input  logic signed [DATA_W-1:0]   req_noise,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]          csr_data,
   output logic signed [DATA_W-1:0]   potential,
   output logic signed [DATA_W-1:0]   recovery,
   output logic                       spiked
);

   localparam int ADDR_W = $clog2(DELAY_DEPTH);
   localparam int EXT_W  = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;
   localparam logic [EXT_W-1:0]  DEPTH_EXT = EXT_W'(DELAY_DEPTH);
   localparam logic [EXT_W-1:0]  LAST_EXT  = EXT_W'(DELAY_DEPTH - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DELAY_DEPTH - 1);

   // configuration
   logic signed [DATA_W-1:0] k_step_ff, v_rest_ff, v_threshold_ff, v_peak_ff;
   logic signed [DATA_W-1:0] v_reset_ff, u_jump_ff, a_step_ff, ab_step_ff;

   // neuron state
   logic signed [DATA_W-1:0] v_ff, u_ff;
   logic                     fired_ff;
   logic [ADDR_W-1:0]        pos_ff, clr_cnt_ff;
   logic                     kind_ff;

   // per-item working registers
   logic signed [DATA_W-1:0]  cur_ff, noise_ff, dr_ff, dt_ff, syn_ff;
   logic signed [DATA_W-1:0]  q_dd_ff, q_au_ff, q_ab_ff, q_k_ff;
   logic signed [DATA_W-1:0]  un_ff, uj_ff, vn_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [ADDR_W-1:0]         addr_ff;

   // next values and helpers
   logic [EXT_W-1:0]          delay_ext, delay_sat, slot_sum, slot_wrap;
   logic [ADDR_W-1:0]         addr_in, pos_in;
   logic signed [DATA_W-1:0]  dr_in, dt_in, accum_in, un_in, uj_in, vn_in, prod_q;
   logic signed [DATA_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_in, prod_sh;
   logic signed [WIDE_W-1:0]  drive_wide;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      mul_en, fire;

   // ring memory ports
   logic                     ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic signed [DATA_W-1:0] ram_rd_data;

   // slot index for an add: delay clamped to the ring, then wrapped
   always_comb begin
      delay_ext = EXT_W'(req_delay);
      delay_sat = (delay_ext > LAST_EXT) ? LAST_EXT : delay_ext;
      slot_sum  = EXT_W'(pos_ff) + delay_sat;
      slot_wrap = (slot_sum >= DEPTH_EXT) ? (slot_sum - DEPTH_EXT) : slot_sum;
      addr_in   = (req_kind == KIND_ADD) ? slot_wrap[ADDR_W-1:0] : pos_ff;
      pos_in    = (pos_ff == LAST_ADDR) ? '0 : (pos_ff + ADDR_W'(1));
   end

   assign dr_in = sat32(WIDE_W'(v_ff) - WIDE_W'(v_rest_ff));
   assign dt_in = sat32(WIDE_W'(v_ff) - WIDE_W'(v_threshold_ff));

   // shared multiplier: operand select per step
   always_comb begin
      mul_a  = dr_ff;
      mul_b  = dt_ff;
      mul_en = 1'b0;
      case (cmd)
         DP_READ: begin
            mul_en = 1'b1;
         end
         DP_MUL_AU: begin
            mul_a  = a_step_ff;
            mul_b  = u_ff;
            mul_en = 1'b1;
         end
         DP_MUL_AB: begin
            mul_a  = ab_step_ff;
            mul_b  = dr_ff;
            mul_en = 1'b1;
         end
         DP_MUL_K: begin
            mul_a  = k_step_ff;
            mul_b  = q_dd_ff;
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign prod_q  = sat32(WIDE_W'(prod_sh));

   assign accum_in   = sat32(WIDE_W'(ram_rd_data) + WIDE_W'(cur_ff));
   assign un_in      = sat32(WIDE_W'(u_ff) + WIDE_W'(q_ab_ff) - WIDE_W'(q_au_ff));
   assign uj_in      = sat32(WIDE_W'(u_ff) + WIDE_W'(u_jump_ff));
   assign drive_wide = WIDE_W'(BIAS_CURRENT) - WIDE_W'(u_ff) + WIDE_W'(syn_ff);
   assign drive_in   = DRIVE_W'(drive_wide >>> GAIN_SHIFT);
   assign vn_in      = sat32(WIDE_W'(v_ff) + WIDE_W'(q_k_ff) + WIDE_W'(drive_ff)
                             + WIDE_W'(noise_ff));
   assign fire       = (vn_ff > v_peak_ff);

   // ring access: clear sweep, read-modify-write for adds, zero on tick
   always_comb begin
      ram_wr_en   = (cmd == DP_CLEAR) || (cmd == DP_ACCUM) || (cmd == DP_MUL_AU);
      ram_wr_addr = (cmd == DP_CLEAR) ? clr_cnt_ff : addr_ff;
      ram_wr_data = (cmd == DP_ACCUM) ? accum_in : '0;
      ram_rd_en   = (cmd == DP_READ);
   end

   izn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DELAY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_step_ff      <= '0;
         v_rest_ff      <= '0;
         v_threshold_ff <= '0;
         v_peak_ff      <= '0;
         v_reset_ff     <= '0;
         u_jump_ff      <= '0;
         a_step_ff      <= '0;
         ab_step_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_K_STEP:      k_step_ff      <= csr_data;
            CSR_V_REST:      v_rest_ff      <= csr_data;
            CSR_V_THRESHOLD: v_threshold_ff <= csr_data;
            CSR_V_PEAK:      v_peak_ff      <= csr_data;
            CSR_V_RESET:     v_reset_ff     <= csr_data;
            CSR_U_JUMP:      u_jump_ff      <= csr_data;
            CSR_A_STEP:      a_step_ff      <= csr_data;
            CSR_AB_STEP:     ab_step_ff     <= csr_data;
         endcase
      end
   end

   // neuron state and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff       <= INITIAL_V;
         u_ff       <= INITIAL_U;
         fired_ff   <= 1'b0;
         pos_ff     <= '0;
         clr_cnt_ff <= '0;
         kind_ff    <= KIND_TICK;
      end else begin
         if (cmd == DP_CLEAR) begin
            clr_cnt_ff <= (clr_cnt_ff == LAST_ADDR) ? '0 : (clr_cnt_ff + ADDR_W'(1));
         end
         if (cmd == DP_LATCH) begin
            kind_ff <= req_kind;
         end
         if (cmd == DP_COMMIT) begin
            pos_ff <= pos_in;
            if (fire) begin
               v_ff     <= v_reset_ff;
               u_ff     <= uj_ff;
               fired_ff <= 1'b1;
            end else begin
               v_ff     <= vn_ff;
               u_ff     <= un_ff;
               fired_ff <= 1'b0;
            end
         end
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      unique case (cmd)
         DP_LATCH: begin
            cur_ff   <= req_current;
            noise_ff <= req_noise;
            addr_ff  <= addr_in;
            dr_ff    <= dr_in;
            dt_ff    <= dt_in;
         end
         DP_MUL_AU: begin
            syn_ff  <= ram_rd_data;
            q_dd_ff <= prod_q;
         end
         DP_MUL_AB: q_au_ff <= prod_q;
         DP_MUL_K:  q_ab_ff <= prod_q;
         DP_SUM: begin
            q_k_ff   <= prod_q;
            un_ff    <= un_in;
            uj_ff    <= uj_in;
            drive_ff <= drive_in;
         end
         DP_VSUM: vn_ff <= vn_in;
         DP_NOP, DP_CLEAR, DP_READ, DP_ACCUM, DP_COMMIT: begin
         end
      endcase
   end

   assign status.kind_add   = kind_ff;
   assign status.clear_last = (clr_cnt_ff == LAST_ADDR);

   assign potential = v_ff;
   assign recovery  = u_ff;
   assign spiked    = fired_ff;

endmodule

`default_nettype wire

### rtl/izhikevich_neuron_step_core.sv
// ---------------------------------------------------------------------------
// izhikevich_neuron_step_core: one Izhikevich neuron, forward Euler, Q16.16
// Top level: sequencer, datapath and delay-ring memory.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item word: a time tick (req_kind 0, uses req_noise) or
//   an add-current word (req_kind 1, uses req_current and req_delay).
//   rsp_* returns one word per item: potential, recovery and the spike flag
//   of the last tick. csr_* writes the eight Q16.16 registers; csr_ready is
//   always high, write only while the core is idle.
// Sequence:
//   A tick runs through READ, MUL_AU, MUL_AB, MUL_K, SUM, VSUM and COMMIT;
//   an add-current word runs through READ, ACCUM and COMMIT. The core takes
//   no new word until it is back in IDLE. The steps come from the single
//   shared 32x32 multiplier (four products per tick, one per cycle) and the
//   registered read of the delay-ring memory.
// Reset:
//   Reset loads INITIAL_V / INITIAL_U, clears the registers and the ring
//   position, then sweeps the ring memory to zero, one slot per cycle across
//   all DELAY_DEPTH slots, with req_ready low. Config writes are taken meanwhile.
// Stall:
//   The result waits in the output registers while rsp_ready is low; the core
//   may accept and work on the next word, and holds before commit until the
//   output word has been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module izhikevich_neuron_step_core
   import izn_pkg::*;
#(
   parameter int                        DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int                        GAIN_SHIFT   = GAIN_SHIFT_DEF,
   parameter logic signed [DATA_W-1:0]  BIAS_CURRENT = BIAS_CURRENT_DEF,
   parameter logic signed [DATA_W-1:0]  INITIAL_V    = INITIAL_V_DEF,
   parameter logic signed [DATA_W-1:0]  INITIAL_U    = INITIAL_U_DEF,
   parameter int                        FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // item words
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [DATA_W-1:0]  req_current,
   input  logic [DELAY_W-1:0]        req_delay,
   input  logic signed [DATA_W-1:0]  req_noise,
   // result words
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_potential,
   output logic signed [DATA_W-1:0]  rsp_recovery,
   output logic                      rsp_spiked,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [DATA_W-1:0]         csr_data
);

   dp_op_type     cmd;
   dp_status_type status;

   // register writes always land at once
   assign csr_ready = 1'b1;

   izn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // the neuron state registers drive the result word directly; they change
   // only at commit, which waits for the output word to be free
   izn_datapath #(
      .DELAY_DEPTH  (DELAY_DEPTH),
      .GAIN_SHIFT   (GAIN_SHIFT),
      .BIAS_CURRENT (BIAS_CURRENT),
      .INITIAL_V    (INITIAL_V),
      .INITIAL_U    (INITIAL_U),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_kind    (req_kind),
      .req_current (req_current),
      .req_delay   (req_delay),
      .req_noise   (req_noise),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .potential   (rsp_potential),
      .recovery    (rsp_recovery),
      .spiked      (rsp_spiked)
   );

   // one word in flight: acceptance drops ready on the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while one is in flight");

   // no words taken during the ring clearing sweep
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd == DP_CLEAR) |-> !req_ready)
      else $error("word accepted during ring clear");

   // state commits only when the pending output word is gone or leaving
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == DP_COMMIT) |-> (!rsp_valid || rsp_ready))
      else $error("state committed over an untaken result word");

   // a commit always raises or keeps a result for the consumer
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd == DP_COMMIT) |=> rsp_valid)
      else $error("commit without result word");

endmodule

`default_nettype wire
